@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the guard's checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/btcg_pkg.sv @@
// ---------------------------------------------------------------------------
// btcg_pkg
// Types, codes and reset values shared by the battery charge guard.
// ---------------------------------------------------------------------------
`default_nettype none

package btcg_pkg;

   localparam int TEMP_W      = 12;
   localparam int VOLT_W      = 13;
   localparam int STATUS_W    = 3;
   localparam int HEALTH_W    = 2;
   localparam int LIMIT_W     = 2;
   localparam int PERIOD_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam int BTCG_PERIOD_NORMAL_MS    = 6000;
   localparam int BTCG_PERIOD_DECREASED_MS = 3000;
   localparam int BTCG_PERIOD_BLOCKED_MS   = 1000;
   localparam int BTCG_PERIOD_EMERGENCY_MS = 1000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RISE_TO_NORMAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RISE_TO_WARM   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RISE_TO_HOT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FALL_TO_WARM   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FALL_TO_NORMAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FALL_TO_COLD   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_VOLT_CRITICAL  = 3'd6;

   // register reset values
   localparam logic signed [TEMP_W-1:0] RST_RISE_TO_NORMAL = -12'sd50;
   localparam logic signed [TEMP_W-1:0] RST_RISE_TO_WARM   = 12'sd450;
   localparam logic signed [TEMP_W-1:0] RST_RISE_TO_HOT    = 12'sd550;
   localparam logic signed [TEMP_W-1:0] RST_FALL_TO_WARM   = 12'sd520;
   localparam logic signed [TEMP_W-1:0] RST_FALL_TO_NORMAL = 12'sd430;
   localparam logic signed [TEMP_W-1:0] RST_FALL_TO_COLD   = -12'sd100;
   localparam logic [VOLT_W-1:0]        RST_VOLT_CRITICAL  = 13'd4000;

   typedef enum logic [STATUS_W-1:0] {
      ST_UNDEF = 3'd0,
      ST_FULL  = 3'd1,
      ST_PART  = 3'd2,
      ST_BVOLT = 3'd3,
      ST_COLD  = 3'd4,
      ST_HOT   = 3'd5
   } status_type;

   localparam logic [HEALTH_W-1:0] HEALTH_GOOD     = 2'd0;
   localparam logic [HEALTH_W-1:0] HEALTH_OVERHEAT = 2'd1;
   localparam logic [HEALTH_W-1:0] HEALTH_COLD     = 2'd2;
   localparam logic [HEALTH_W-1:0] HEALTH_STALE    = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_BLOCKED = 2'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_FULL    = 2'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_PARTIAL = 2'd2;

   typedef struct packed {
      logic signed [TEMP_W-1:0] rise_to_normal;
      logic signed [TEMP_W-1:0] rise_to_warm;
      logic signed [TEMP_W-1:0] rise_to_hot;
      logic signed [TEMP_W-1:0] fall_to_warm;
      logic signed [TEMP_W-1:0] fall_to_normal;
      logic signed [TEMP_W-1:0] fall_to_cold;
      logic [VOLT_W-1:0]        volt_critical_mv;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [VOLT_W-1:0]        voltage_mv;
      logic                     reading_valid;
   } reading_type;

   typedef struct packed {
      status_type            charge_status;
      logic [HEALTH_W-1:0]   health;
      logic [LIMIT_W-1:0]    limit_class;
      logic [PERIOD_W-1:0]   next_period_ms;
      logic                  status_changed;
      logic                  wake_hold;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/btcg_if.sv @@
// ---------------------------------------------------------------------------
// btcg_if
// Valid/ready channels for battery readings and guard results.
// ---------------------------------------------------------------------------
`default_nettype none

interface btcg_req_if
   import btcg_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [VOLT_W-1:0]        voltage_mv;
   logic                     reading_valid;

   modport source (output valid, output temperature, output voltage_mv,
                   output reading_valid, input ready);
   modport sink   (input valid, input temperature, input voltage_mv,
                   input reading_valid, output ready);
endinterface

interface btcg_rsp_if
   import btcg_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   charge_status;
   logic [HEALTH_W-1:0]   health;
   logic [LIMIT_W-1:0]    limit_class;
   logic [PERIOD_W-1:0]   next_period_ms;
   logic                  status_changed;
   logic                  wake_hold;

   modport source (output valid, output charge_status, output health,
                   output limit_class, output next_period_ms,
                   output status_changed, output wake_hold, input ready);
   modport sink   (input valid, input charge_status, input health,
                   input limit_class, input next_period_ms,
                   input status_changed, input wake_hold, output ready);
endinterface

`default_nettype wire

@@ hdl/btcg_csr.sv @@
// ---------------------------------------------------------------------------
// btcg_csr
// Threshold registers, written through a plain indexed write port.
// ---------------------------------------------------------------------------
`default_nettype none

module btcg_csr
   import btcg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RISE_TO_NORMAL: cfg_in.rise_to_normal   = csr_wdata[TEMP_W-1:0];
            REG_RISE_TO_WARM:   cfg_in.rise_to_warm     = csr_wdata[TEMP_W-1:0];
            REG_RISE_TO_HOT:    cfg_in.rise_to_hot      = csr_wdata[TEMP_W-1:0];
            REG_FALL_TO_WARM:   cfg_in.fall_to_warm     = csr_wdata[TEMP_W-1:0];
            REG_FALL_TO_NORMAL: cfg_in.fall_to_normal   = csr_wdata[TEMP_W-1:0];
            REG_FALL_TO_COLD:   cfg_in.fall_to_cold     = csr_wdata[TEMP_W-1:0];
            REG_VOLT_CRITICAL:  cfg_in.volt_critical_mv = csr_wdata[VOLT_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_to_normal   <= RST_RISE_TO_NORMAL;
         cfg_ff.rise_to_warm     <= RST_RISE_TO_WARM;
         cfg_ff.rise_to_hot      <= RST_RISE_TO_HOT;
         cfg_ff.fall_to_warm     <= RST_FALL_TO_WARM;
         cfg_ff.fall_to_normal   <= RST_FALL_TO_NORMAL;
         cfg_ff.fall_to_cold     <= RST_FALL_TO_COLD;
         cfg_ff.volt_critical_mv <= RST_VOLT_CRITICAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/btcg_input_stage.sv @@
// ---------------------------------------------------------------------------
// btcg_input_stage
// Input register for one reading; refills in the cycle it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module btcg_input_stage
   import btcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   btcg_req_if.sink    req_chan,
   input  logic        advance,
   output logic        in_valid,
   output reading_type reading
);

   logic        valid_ff;
   logic        valid_in;
   reading_type reading_ff;
   logic        load;

   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         reading_ff.temperature   <= req_chan.temperature;
         reading_ff.voltage_mv    <= req_chan.voltage_mv;
         reading_ff.reading_valid <= req_chan.reading_valid;
      end
   end

   assign in_valid = valid_ff;
   assign reading  = reading_ff;

endmodule

`default_nettype wire

@@ hdl/btcg_status_fsm.sv @@
// ---------------------------------------------------------------------------
// btcg_status_fsm
// Six-state thermal hysteresis machine with the wake hold flag; builds the
// result for the reading held in the input register.
// ---------------------------------------------------------------------------
`default_nettype none

module btcg_status_fsm
   import btcg_pkg::*;
#(
   parameter int PERIOD_NORMAL_MS    = BTCG_PERIOD_NORMAL_MS,
   parameter int PERIOD_DECREASED_MS = BTCG_PERIOD_DECREASED_MS,
   parameter int PERIOD_BLOCKED_MS   = BTCG_PERIOD_BLOCKED_MS,
   parameter int PERIOD_EMERGENCY_MS = BTCG_PERIOD_EMERGENCY_MS
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  reading_type reading,
   input  logic        advance,
   output result_type  result
);

   localparam logic [PERIOD_W-1:0] P_NORMAL    = PERIOD_W'(PERIOD_NORMAL_MS);
   localparam logic [PERIOD_W-1:0] P_DECREASED = PERIOD_W'(PERIOD_DECREASED_MS);
   localparam logic [PERIOD_W-1:0] P_BLOCKED   = PERIOD_W'(PERIOD_BLOCKED_MS);
   localparam logic [PERIOD_W-1:0] P_EMERGENCY = PERIOD_W'(PERIOD_EMERGENCY_MS);

   status_type status_ff;
   status_type status_in;
   logic       hold_ff;
   logic       hold_in;

   logic signed [TEMP_W-1:0] temp;
   logic signed [TEMP_W-1:0] cold_exit;
   logic signed [TEMP_W-1:0] normal_edge;
   logic signed [TEMP_W-1:0] hot_edge;
   logic signed [TEMP_W-1:0] hot_bound;
   logic signed [TEMP_W-1:0] cold_bound;
   logic                     changed;

   assign temp       = reading.temperature;
   assign hot_bound  = cfg.rise_to_hot;
   assign cold_bound = cfg.fall_to_cold;

   // next state
   always_comb begin
      cold_exit   = cfg.fall_to_cold;
      normal_edge = cfg.rise_to_warm;
      hot_edge    = cfg.rise_to_hot;
      unique case (status_ff) inside
         ST_COLD: begin
            cold_exit = cfg.rise_to_normal;
         end
         ST_PART, ST_BVOLT: begin
            normal_edge = cfg.fall_to_normal;
         end
         ST_HOT: begin
            normal_edge = cfg.fall_to_normal;
            hot_edge    = cfg.fall_to_warm;
         end
         default: begin
            // undefined and full keep the rising edges
         end
      endcase

      if (!reading.reading_valid) begin
         status_in = status_ff;
      end else if (temp < cold_exit) begin
         status_in = ST_COLD;
      end else if (temp < normal_edge) begin
         status_in = ST_FULL;
      end else if (temp < hot_edge) begin
         status_in = (reading.voltage_mv > cfg.volt_critical_mv) ? ST_BVOLT : ST_PART;
      end else begin
         status_in = ST_HOT;
      end
   end

   // outputs
   always_comb begin
      changed = (status_in != status_ff);
      hold_in = hold_ff;
      if (changed) begin
         hold_in = !(status_in == ST_FULL || status_in == ST_PART);
      end

      result.charge_status  = status_in;
      result.status_changed = changed;
      result.wake_hold      = hold_in;

      if (!reading.reading_valid) begin
         result.health = HEALTH_STALE;
      end else if (hot_bound < temp) begin
         result.health = HEALTH_OVERHEAT;
      end else if (temp < cold_bound) begin
         result.health = HEALTH_COLD;
      end else begin
         result.health = HEALTH_GOOD;
      end

      unique case (status_in) inside
         ST_BVOLT, ST_COLD, ST_HOT: begin
            result.limit_class    = LIMIT_BLOCKED;
            result.next_period_ms = P_BLOCKED;
         end
         ST_PART: begin
            result.limit_class    = LIMIT_PARTIAL;
            result.next_period_ms = P_DECREASED;
         end
         ST_FULL: begin
            result.limit_class    = LIMIT_FULL;
            result.next_period_ms = P_NORMAL;
         end
         default: begin
            result.limit_class    = LIMIT_FULL;
            result.next_period_ms = P_EMERGENCY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_UNDEF;
         hold_ff   <= 1'b0;
      end else if (advance) begin
         status_ff <= status_in;
         hold_ff   <= hold_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/btcg_output_stage.sv @@
// ---------------------------------------------------------------------------
// btcg_output_stage
// Result register driving the response channel.
// ---------------------------------------------------------------------------
`default_nettype none

module btcg_output_stage
   import btcg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   btcg_rsp_if.source rsp_chan,
   input  logic       advance,
   input  result_type result,
   output logic       out_free
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.charge_status  = result_ff.charge_status;
   assign rsp_chan.health         = result_ff.health;
   assign rsp_chan.limit_class    = result_ff.limit_class;
   assign rsp_chan.next_period_ms = result_ff.next_period_ms;
   assign rsp_chan.status_changed = result_ff.status_changed;
   assign rsp_chan.wake_hold      = result_ff.wake_hold;

endmodule

`default_nettype wire

@@ hdl/battery_thermal_charge_guard_top.sv @@
// ---------------------------------------------------------------------------
// battery_thermal_charge_guard_top
// Thermal and voltage charge guard: one status result per battery reading.
// ---------------------------------------------------------------------------
// Each accepted reading is captured in the input register, the hysteresis
// machine decides the new status in one pass of compares and selects, and
// the result register presents it. One reading is accepted every cycle
// unless the response stalls; the status register is updated as a reading
// moves into the result register, so the next reading sees it. A stalled
// response holds the result and backs up into the input register.
// The user writes threshold registers only while idle; it is not enforced.
// ---------------------------------------------------------------------------
`default_nettype none

module battery_thermal_charge_guard_top
   import btcg_pkg::*;
#(
   parameter int PERIOD_NORMAL_MS    = BTCG_PERIOD_NORMAL_MS,
   parameter int PERIOD_DECREASED_MS = BTCG_PERIOD_DECREASED_MS,
   parameter int PERIOD_BLOCKED_MS   = BTCG_PERIOD_BLOCKED_MS,
   parameter int PERIOD_EMERGENCY_MS = BTCG_PERIOD_EMERGENCY_MS
)
(
   input  logic                   clock,
   input  logic                   reset,
   btcg_req_if.sink               req_chan,
   btcg_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg;
   reading_type reading;
   result_type  result;
   logic        in_valid;
   logic        out_free;
   logic        advance;

   // move the held reading into the result register
   assign advance = in_valid && out_free;

   btcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btcg_input_stage u_input_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_valid (in_valid),
      .reading  (reading)
   );

   btcg_status_fsm #(
      .PERIOD_NORMAL_MS    (PERIOD_NORMAL_MS),
      .PERIOD_DECREASED_MS (PERIOD_DECREASED_MS),
      .PERIOD_BLOCKED_MS   (PERIOD_BLOCKED_MS),
      .PERIOD_EMERGENCY_MS (PERIOD_EMERGENCY_MS)
   ) u_status_fsm (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .reading (reading),
      .advance (advance),
      .result  (result)
   );

   btcg_output_stage u_output_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .advance  (advance),
      .result   (result),
      .out_free (out_free)
   );

endmodule

`default_nettype wire

@@ hdl/btcg_checker.sv @@
// ---------------------------------------------------------------------------
// btcg_checker
// Port-level checks on the guard's results, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module btcg_checker
   import btcg_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_charge_status,
   input logic [HEALTH_W-1:0] rsp_health,
   input logic [LIMIT_W-1:0]  rsp_limit_class,
   input logic                rsp_status_changed,
   input logic                rsp_wake_hold
);

   logic rsp_stall;
   logic rsp_blocked;
   logic rsp_released;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_blocked  = rsp_charge_status == ST_BVOLT || rsp_charge_status == ST_COLD
                         || rsp_charge_status == ST_HOT;
   assign rsp_released = rsp_charge_status == ST_FULL || rsp_charge_status == ST_PART;

   // a stale reading never moves the status
   `ASSERT_IMPLY(a_stale_no_change, clock, reset, rsp_valid && rsp_health == HEALTH_STALE, !rsp_status_changed)

   // a change into a blocked state takes the hold, into a charging state drops it
   `ASSERT_IMPLY(a_hold_follows_change, clock, reset, rsp_valid && rsp_status_changed, rsp_wake_hold == rsp_blocked)

   // blocked states always report the blocked limit
   `ASSERT_IMPLY(a_blocked_limit, clock, reset, rsp_valid && rsp_blocked, rsp_limit_class == LIMIT_BLOCKED && !rsp_released)

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_charge_status) && $stable(rsp_wake_hold))

endmodule

bind battery_thermal_charge_guard_top btcg_checker u_btcg_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_charge_status  (rsp_chan.charge_status),
   .rsp_health         (rsp_chan.health),
   .rsp_limit_class    (rsp_chan.limit_class),
   .rsp_status_changed (rsp_chan.status_changed),
   .rsp_wake_hold      (rsp_chan.wake_hold)
);

`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the battery thermal charge guard. Readings go in
// on the request channel with random gaps, results are drained with random
// stalls, and every result is checked field by field against a predictor of
// the hysteresis machine held in a small scoreboard. Threshold settings are
// swapped between phases while the block is idle.
// ---------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import btcg_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int STALL_LIMIT   = 1000;
   localparam int PHASES        = 12;
   localparam int BEATS_PER_SET = 140;
   localparam int MAX_REPORTS   = 10;

   class charge_guard_scoreboard;
      cfg_type    thr;
      status_type status;
      logic       hold;
      result_type pending_results[$];
      int         mismatches;

      function new();
         thr.rise_to_normal   = RST_RISE_TO_NORMAL;
         thr.rise_to_warm     = RST_RISE_TO_WARM;
         thr.rise_to_hot      = RST_RISE_TO_HOT;
         thr.fall_to_warm     = RST_FALL_TO_WARM;
         thr.fall_to_normal   = RST_FALL_TO_NORMAL;
         thr.fall_to_cold     = RST_FALL_TO_COLD;
         thr.volt_critical_mv = RST_VOLT_CRITICAL;
         status     = ST_UNDEF;
         hold       = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_RISE_TO_NORMAL: thr.rise_to_normal   = data[TEMP_W-1:0];
            REG_RISE_TO_WARM:   thr.rise_to_warm     = data[TEMP_W-1:0];
            REG_RISE_TO_HOT:    thr.rise_to_hot      = data[TEMP_W-1:0];
            REG_FALL_TO_WARM:   thr.fall_to_warm     = data[TEMP_W-1:0];
            REG_FALL_TO_NORMAL: thr.fall_to_normal   = data[TEMP_W-1:0];
            REG_FALL_TO_COLD:   thr.fall_to_cold     = data[TEMP_W-1:0];
            REG_VOLT_CRITICAL:  thr.volt_critical_mv = data[VOLT_W-1:0];
            default: ;
         endcase
      endfunction

      function status_type next_status(logic signed [TEMP_W-1:0] t, logic [VOLT_W-1:0] v);
         logic signed [TEMP_W-1:0] cold_exit;
         logic signed [TEMP_W-1:0] normal_edge;
         logic signed [TEMP_W-1:0] hot_edge;
         cold_exit   = thr.fall_to_cold;
         normal_edge = thr.rise_to_warm;
         hot_edge    = thr.rise_to_hot;
         // exit edges depend on where the machine sits now
         case (status)
            ST_COLD: cold_exit = thr.rise_to_normal;
            ST_PART, ST_BVOLT: normal_edge = thr.fall_to_normal;
            ST_HOT: begin
               normal_edge = thr.fall_to_normal;
               hot_edge    = thr.fall_to_warm;
            end
            default: ;
         endcase
         if (t < cold_exit) return ST_COLD;
         if (t < normal_edge) return ST_FULL;
         if (t < hot_edge) return (v > thr.volt_critical_mv) ? ST_BVOLT : ST_PART;
         return ST_HOT;
      endfunction

      function void note_reading(reading_type rd);
         logic signed [TEMP_W-1:0] t;
         logic signed [TEMP_W-1:0] hot_bound;
         logic signed [TEMP_W-1:0] cold_bound;
         status_type nxt;
         result_type res;
         t          = rd.temperature;
         hot_bound  = thr.rise_to_hot;
         cold_bound = thr.fall_to_cold;
         nxt        = status;
         res.health = HEALTH_STALE;
         if (rd.reading_valid) begin
            if (hot_bound < t) res.health = HEALTH_OVERHEAT;
            else if (t < cold_bound) res.health = HEALTH_COLD;
            else res.health = HEALTH_GOOD;
            nxt = next_status(t, rd.voltage_mv);
         end
         res.status_changed = (nxt != status);
         if (nxt != status) hold = !(nxt == ST_FULL || nxt == ST_PART);
         status = nxt;
         res.charge_status = nxt;
         res.wake_hold     = hold;
         case (nxt)
            ST_BVOLT, ST_COLD, ST_HOT: begin
               res.limit_class    = LIMIT_BLOCKED;
               res.next_period_ms = PERIOD_W'(BTCG_PERIOD_BLOCKED_MS);
            end
            ST_PART: begin
               res.limit_class    = LIMIT_PARTIAL;
               res.next_period_ms = PERIOD_W'(BTCG_PERIOD_DECREASED_MS);
            end
            ST_FULL: begin
               res.limit_class    = LIMIT_FULL;
               res.next_period_ms = PERIOD_W'(BTCG_PERIOD_NORMAL_MS);
            end
            default: begin
               res.limit_class    = LIMIT_FULL;
               res.next_period_ms = PERIOD_W'(BTCG_PERIOD_EMERGENCY_MS);
            end
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing expected: status %0d health %0d",
                        $realtime, got.charge_status, got.health);
            return;
         end
         exp = pending_results.pop_front();
         if (got.charge_status !== exp.charge_status || got.health !== exp.health ||
             got.limit_class !== exp.limit_class || got.next_period_ms !== exp.next_period_ms ||
             got.status_changed !== exp.status_changed || got.wake_hold !== exp.wake_hold) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: mismatch exp st %0d hl %0d lim %0d per %0d chg %0b hold %0b | got st %0d hl %0d lim %0d per %0d chg %0b hold %0b",
                        $realtime, exp.charge_status, exp.health, exp.limit_class,
                        exp.next_period_ms, exp.status_changed, exp.wake_hold,
                        got.charge_status, got.health, got.limit_class,
                        got.next_period_ms, got.status_changed, got.wake_hold);
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   btcg_req_if req_chan();
   btcg_rsp_if rsp_chan();

   charge_guard_scoreboard guard = new();

   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int walk_temp = 0;
   int idle_cycles = 0;

   battery_thermal_charge_guard_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // monitor both channels
   always @(posedge clock) begin
      reading_type rd;
      result_type  got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            rd.temperature   = req_chan.temperature;
            rd.voltage_mv    = req_chan.voltage_mv;
            rd.reading_valid = req_chan.reading_valid;
            guard.note_reading(rd);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.charge_status  = status_type'(rsp_chan.charge_status);
            got.health         = rsp_chan.health;
            got.limit_class    = rsp_chan.limit_class;
            got.next_period_ms = rsp_chan.next_period_ms;
            got.status_changed = rsp_chan.status_changed;
            got.wake_hold      = rsp_chan.wake_hold;
            guard.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result sink: random stall before each beat
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   task automatic send_reading(int t, int v, bit ok);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.temperature   <= t[TEMP_W-1:0];
      req_chan.voltage_mv    <= v[VOLT_W-1:0];
      req_chan.reading_valid <= ok;
      req_chan.valid         <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // drop valid and wait until every expected result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (guard.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      guard.set_reg(idx, data[CSR_DATA_W-1:0]);
      @(negedge clock);
   endtask

   task automatic apply_settings(int kind);
      int t[6];
      int crit;
      case (kind)
         0: begin
            t = '{RST_RISE_TO_NORMAL, RST_RISE_TO_WARM, RST_RISE_TO_HOT,
                  RST_FALL_TO_WARM, RST_FALL_TO_NORMAL, RST_FALL_TO_COLD};
            crit = RST_VOLT_CRITICAL;
         end
         1: begin
            t = '{-2048, -2048, -2048, -2048, -2048, -2048};
            crit = 0;
         end
         2: begin
            t = '{2047, 2047, 2047, 2047, 2047, 2047};
            crit = 8191;
         end
         3: begin
            foreach (t[i]) t[i] = $urandom_range(0, 8191);
            crit = $urandom_range(0, 8191);
         end
         default: begin
            // ordered: fall_cold < rise_normal < fall_normal < rise_warm < fall_warm < rise_hot
            t[5] = $urandom_range(0, 2000) - 1500;
            t[0] = t[5] + $urandom_range(1, 150);
            t[4] = t[0] + $urandom_range(1, 150);
            t[1] = t[4] + $urandom_range(1, 150);
            t[3] = t[1] + $urandom_range(1, 150);
            t[2] = t[3] + $urandom_range(1, 150);
            crit = $urandom_range(0, 8191);
         end
      endcase
      write_reg(REG_RISE_TO_NORMAL, t[0]);
      write_reg(REG_RISE_TO_WARM, t[1]);
      write_reg(REG_RISE_TO_HOT, t[2]);
      write_reg(REG_FALL_TO_WARM, t[3]);
      write_reg(REG_FALL_TO_NORMAL, t[4]);
      write_reg(REG_FALL_TO_COLD, t[5]);
      write_reg(REG_VOLT_CRITICAL, crit);
      if ($urandom_range(0, 1)) write_reg(REG_UNMAPPED, $urandom_range(0, 8191));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_reading();
      int sel;
      int v;
      int crit;
      logic signed [TEMP_W-1:0] edge_pick;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         walk_temp += $urandom_range(0, 80) - 40;
      end else if (sel < 9) begin
         case ($urandom_range(0, 5))
            0: edge_pick = guard.thr.rise_to_normal;
            1: edge_pick = guard.thr.rise_to_warm;
            2: edge_pick = guard.thr.rise_to_hot;
            3: edge_pick = guard.thr.fall_to_warm;
            4: edge_pick = guard.thr.fall_to_normal;
            default: edge_pick = guard.thr.fall_to_cold;
         endcase
         walk_temp = int'(edge_pick) + $urandom_range(0, 4) - 2;
      end else begin
         walk_temp = $urandom_range(0, 4095) - 2048;
      end
      if (walk_temp > 2047) walk_temp = 2047;
      if (walk_temp < -2048) walk_temp = -2048;
      crit = guard.thr.volt_critical_mv;
      if ($urandom_range(0, 1)) begin
         v = crit + $urandom_range(0, 4) - 2;
         if (v < 0) v = 0;
         if (v > 8191) v = 8191;
      end else begin
         v = $urandom_range(0, 8191);
      end
      send_reading(walk_temp, v, $urandom_range(0, 9) != 0);
   endtask

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.temperature   = '0;
      req_chan.voltage_mv    = '0;
      req_chan.reading_valid = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through every status at the reset thresholds
      send_reading(0, 3700, 0);
      send_reading(-2048, 0, 1);
      send_reading(-75, 8191, 1);
      send_reading(-50, 3700, 1);
      send_reading(-100, 3700, 1);
      send_reading(-101, 3700, 1);
      send_reading(2047, 8191, 0);
      send_reading(450, 4000, 1);
      send_reading(440, 4001, 1);
      send_reading(430, 0, 1);
      send_reading(429, 8191, 1);
      send_reading(549, 8191, 1);
      send_reading(550, 0, 1);
      send_reading(551, 0, 1);
      send_reading(520, 0, 1);
      send_reading(519, 4000, 1);
      send_reading(2047, 8191, 1);
      send_reading(-1, 0, 1);
      send_reading(-2048, 8191, 1);
      send_reading(2047, 0, 1);
      send_reading(-2048, 0, 0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         apply_settings(p < 4 ? p : $urandom_range(3, 6));
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         walk_temp = $urandom_range(0, 1200) - 400;
         for (int n = 0; n < BEATS_PER_SET; n++) begin
            send_random_reading();
            // hold off mid-phase until the pipe is empty
            if (n == BEATS_PER_SET / 2 && p % 3 == 1) drain();
         end
         drain();
      end

      repeat (8) @(negedge clock);
      if (guard.mismatches == 0 && guard.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
